// ----- rtl/rek_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rek_pkg
// Types, register map and direction table shared by the knob decoder modules.
// ----------------------------------------------------------------------------
package rek_pkg;

    typedef logic [1:0] dir_t;

    localparam dir_t DIR_NONE = 2'd0;
    localparam dir_t DIR_UP   = 2'd1;
    localparam dir_t DIR_DOWN = 2'd2;

    // indexed by {previous A, previous B, current A, current B}
    localparam dir_t DIR_TABLE [16] = '{
        DIR_NONE, DIR_DOWN, DIR_UP,   DIR_NONE,
        DIR_UP,   DIR_NONE, DIR_NONE, DIR_DOWN,
        DIR_DOWN, DIR_NONE, DIR_NONE, DIR_UP,
        DIR_NONE, DIR_UP,   DIR_DOWN, DIR_NONE
    };

    localparam int  ADDR_W     = 5;
    localparam int  DATA_W     = 32;
    localparam int  IN_TDATA_W = 40;
    localparam int  OUT_DATA_W = 8;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_SLOW_STEP   = 3'd0;
    localparam logic [2:0] REG_FAST_STEP   = 3'd1;
    localparam logic [2:0] REG_MAX_VALUE   = 3'd2;
    localparam logic [2:0] REG_WRAP_MODE   = 3'd3;
    localparam logic [2:0] REG_FAST_WINDOW = 3'd4;

    localparam logic [7:0]  SLOW_STEP_RST   = 8'd1;
    localparam logic [7:0]  FAST_STEP_RST   = 8'd4;
    localparam logic [7:0]  MAX_VALUE_RST   = 8'd255;
    localparam logic        WRAP_MODE_RST   = 1'b0;
    localparam logic [31:0] FAST_WINDOW_RST = 32'd10;

    typedef struct packed {
        logic [7:0]  slow_step;
        logic [7:0]  fast_step;
        logic [7:0]  max_value;
        logic        wrap_mode;
        logic [31:0] fast_window;
    } rek_cfg_t;

    typedef struct packed {
        logic [1:0]  prev_pins;   // A in bit 1, B in bit 0
        dir_t        prev_dir;
        logic [31:0] last_time;
        logic [7:0]  value;
    } rek_state_t;

endpackage

// ----- rtl/rek_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rek_cfg
// APB register bank: step sizes, upper limit, wrap mode and fast window.
// ----------------------------------------------------------------------------
module rek_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rek_pkg::ADDR_W-1:0]    paddr,
    input  logic [rek_pkg::DATA_W-1:0]    pwdata,
    output logic [rek_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output rek_pkg::rek_cfg_t             cfg
);

    rek_pkg::rek_cfg_t cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_step   <= rek_pkg::SLOW_STEP_RST;
            cfg_reg.fast_step   <= rek_pkg::FAST_STEP_RST;
            cfg_reg.max_value   <= rek_pkg::MAX_VALUE_RST;
            cfg_reg.wrap_mode   <= rek_pkg::WRAP_MODE_RST;
            cfg_reg.fast_window <= rek_pkg::FAST_WINDOW_RST;
        end else if (wr_en) begin
            case (reg_idx)
                rek_pkg::REG_SLOW_STEP:   cfg_reg.slow_step   <= pwdata[7:0];
                rek_pkg::REG_FAST_STEP:   cfg_reg.fast_step   <= pwdata[7:0];
                rek_pkg::REG_MAX_VALUE:   cfg_reg.max_value   <= pwdata[7:0];
                rek_pkg::REG_WRAP_MODE:   cfg_reg.wrap_mode   <= pwdata[0];
                rek_pkg::REG_FAST_WINDOW: cfg_reg.fast_window <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rek_pkg::REG_SLOW_STEP:   prdata = {24'd0, cfg_reg.slow_step};
            rek_pkg::REG_FAST_STEP:   prdata = {24'd0, cfg_reg.fast_step};
            rek_pkg::REG_MAX_VALUE:   prdata = {24'd0, cfg_reg.max_value};
            rek_pkg::REG_WRAP_MODE:   prdata = {31'd0, cfg_reg.wrap_mode};
            rek_pkg::REG_FAST_WINDOW: prdata = cfg_reg.fast_window;
            default:                  prdata = '0;
        endcase
    end

endmodule

// ----- rtl/rek_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rek_step
// Next-state logic for one encoder sample: direction, speed, step and limit.
// ----------------------------------------------------------------------------
module rek_step (
    input  rek_pkg::rek_cfg_t   cfg,
    input  rek_pkg::rek_state_t state,
    input  logic                kind,
    input  logic [1:0]          pins,
    input  logic [31:0]         tick_time,
    output rek_pkg::rek_state_t state_next,
    output logic                changed
);

    rek_pkg::dir_t      dir;
    logic [31:0]        delta;
    logic               fast;
    logic [7:0]         step;
    logic signed [9:0]  sum;
    logic               over;
    logic               under;
    logic [7:0]         value_new;

    assign dir   = rek_pkg::DIR_TABLE[{state.prev_pins, pins}];
    assign delta = tick_time - state.last_time;
    assign fast  = (dir == state.prev_dir) && (delta < cfg.fast_window);
    assign step  = fast ? cfg.fast_step : cfg.slow_step;
    assign sum   = (dir == rek_pkg::DIR_UP) ? $signed({2'b00, state.value} + {2'b00, step})
                                            : $signed({2'b00, state.value} - {2'b00, step});
    assign under = sum[9];
    assign over  = !sum[9] && (sum[8:0] > {1'b0, cfg.max_value});

    always_comb begin
        if (over) begin
            value_new = cfg.wrap_mode ? 8'd0 : cfg.max_value;
        end else if (under) begin
            value_new = cfg.wrap_mode ? cfg.max_value : 8'd0;
        end else begin
            value_new = sum[7:0];
        end
    end

    always_comb begin
        state_next = state;
        changed    = 1'b0;
        if (kind) begin
            state_next.prev_pins = pins;
        end else if (dir != rek_pkg::DIR_NONE) begin
            state_next.prev_pins = pins;
            state_next.prev_dir  = dir;
            state_next.last_time = tick_time;
            state_next.value     = value_new;
            changed              = 1'b1;
        end
    end

endmodule

// ----- rtl/rotary_encoder_accel_knob_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_accel_knob_unit
// Quadrature knob decoder with speed-dependent step, clamp or wrap limits.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                               tuser
//  s_       in   [0] pin_a [1] pin_b [33:2] tick     [0] kind
//  m_       out  [7:0] knob_value                    [0] changed
//  apb      in   5 registers at 0x00..0x10           -
//
//  one transaction per clock while m_ is not stalled: the sample is decoded in the
//  accept cycle and the result lands in the output register on the same edge
//  s_tready stays high while the output register is empty or being drained
//  a stall on m_ holds the result; s_ then waits until m_tready returns
//  synchronous active-low reset restores the register defaults and clears state
// ----------------------------------------------------------------------------
module rotary_encoder_accel_knob_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rek_pkg::IN_TDATA_W-1:0]      s_tdata,   // pin_a, pin_b, tick_time, pad
    input  logic [0:0]                          s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rek_pkg::OUT_DATA_W-1:0]      m_tdata,   // knob_value
    output logic [0:0]                          m_tuser,   // changed
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rek_pkg::ADDR_W-1:0]          paddr,
    input  logic [rek_pkg::DATA_W-1:0]          pwdata,
    output logic [rek_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    rek_pkg::rek_cfg_t   cfg;
    rek_pkg::rek_state_t state_reg;
    rek_pkg::rek_state_t state_next;
    logic                changed_next;
    logic                s_accept;
    logic                m_tvalid_reg;
    logic [7:0]          m_tdata_reg;
    logic                m_tuser_reg;

    rek_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rek_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .kind       (s_tuser[0]),
        .pins       ({s_tdata[0], s_tdata[1]}),
        .tick_time  (s_tdata[33:2]),
        .state_next (state_next),
        .changed    (changed_next)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= state_next.value;
            m_tuser_reg <= changed_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // capture transaction never reports a change nor moves the value
    a_capture_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser[0]) |=> (m_tvalid && !m_tuser[0]
            && state_reg.value == $past(state_reg.value)))
        else $error("capture transaction altered the knob value");

    // result register shows the tracked value
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tdata == state_reg.value))
        else $error("result value differs from tracked value");

    // input only blocks while a result is waiting
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output register");

    // the time stamp moves only with a reported change
    a_time_on_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !changed_next) |=> $stable(state_reg.last_time))
        else $error("tick stamp updated without a valid step");

endmodule

// ----- bench/rotary_encoder_accel_knob_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_accel_knob_unit_tb
// Self-checking bench for the quadrature knob decoder. Sample and capture
// transactions go in on the s_ stream, a local predictor computes the
// changed flag and knob value of every transaction, and each m_ transaction
// is checked against the oldest prediction. Register settings are changed
// over APB between phases, both stream sides idle in random bursts, and the
// m_ side holds off once for a long stretch so that s_ backs up.
// ----------------------------------------------------------------------------
module rotary_encoder_accel_knob_unit_tb;

    localparam int RAND_PER_PHASE = 175;
    localparam int PHASES         = 8;
    localparam int QUIET_LIMIT    = 5000;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 250;

    // quadrature direction per {previous A, previous B, current A, current B}
    localparam rek_pkg::dir_t QUAD_DIR [16] = '{
        rek_pkg::DIR_NONE, rek_pkg::DIR_DOWN, rek_pkg::DIR_UP,   rek_pkg::DIR_NONE,
        rek_pkg::DIR_UP,   rek_pkg::DIR_NONE, rek_pkg::DIR_NONE, rek_pkg::DIR_DOWN,
        rek_pkg::DIR_DOWN, rek_pkg::DIR_NONE, rek_pkg::DIR_NONE, rek_pkg::DIR_UP,
        rek_pkg::DIR_NONE, rek_pkg::DIR_UP,   rek_pkg::DIR_DOWN, rek_pkg::DIR_NONE
    };
    // next pin pair when turning up or down, indexed by the current pair
    localparam logic [1:0] UP_NEXT   [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
    localparam logic [1:0] DOWN_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

    typedef struct packed {
        logic        kind;
        logic        pin_a;
        logic        pin_b;
        logic [31:0] tick;
    } knob_item_t;

    typedef struct packed {
        logic       changed;
        logic [7:0] value;
    } knob_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [rek_pkg::IN_TDATA_W-1:0] s_tdata  = '0;  // [0] pin_a, [1] pin_b, [33:2] tick_time
    logic [0:0]                     s_tuser  = '0;  // [0] kind
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rek_pkg::OUT_DATA_W-1:0] m_tdata;        // [7:0] knob_value
    logic [0:0]                     m_tuser;        // [0] changed
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [rek_pkg::ADDR_W-1:0]     paddr    = '0;
    logic [rek_pkg::DATA_W-1:0]     pwdata   = '0;
    logic [rek_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    knob_item_t   knob_stimulus [$];
    knob_result_t knob_expected [$];

    rek_pkg::rek_cfg_t   knob_cfg;
    rek_pkg::rek_state_t knob_st;

    int   err_count    = 0;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   s_gap        = 0;
    int   m_gap        = 0;
    int   hold_cnt     = 0;
    bit   jitter       = 1'b1;

    logic [1:0]  walk_pins = 2'd0;
    bit          walk_up   = 1'b1;
    logic [31:0] tick_now  = '0;

    rotary_encoder_accel_knob_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // decode one accepted transaction and advance the knob state
    function automatic knob_result_t advance_knob(input logic kind, input logic [1:0] pins,
                                                  input logic [31:0] now);
        knob_result_t  res;
        rek_pkg::dir_t dir;
        logic [31:0]   delta;
        int            stp;
        int            sum;
        res.changed = 1'b0;
        if (kind) begin
            knob_st.prev_pins = pins;
        end else begin
            dir = QUAD_DIR[{knob_st.prev_pins, pins}];
            if (dir != rek_pkg::DIR_NONE) begin
                delta = now - knob_st.last_time;
                if (dir == knob_st.prev_dir && delta < knob_cfg.fast_window)
                    stp = int'(knob_cfg.fast_step);
                else
                    stp = int'(knob_cfg.slow_step);
                if (dir == rek_pkg::DIR_UP)
                    sum = int'(knob_st.value) + stp;
                else
                    sum = int'(knob_st.value) - stp;
                if (sum > int'(knob_cfg.max_value))
                    knob_st.value = knob_cfg.wrap_mode ? 8'd0 : knob_cfg.max_value;
                else if (sum < 0)
                    knob_st.value = knob_cfg.wrap_mode ? knob_cfg.max_value : 8'd0;
                else
                    knob_st.value = sum[7:0];
                knob_st.prev_dir  = dir;
                knob_st.prev_pins = pins;
                knob_st.last_time = now;
                res.changed = 1'b1;
            end
        end
        res.value = knob_st.value;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic push_item(input logic kind, input logic [1:0] pins, input logic [31:0] tick);
        knob_item_t it;
        it.kind  = kind;
        it.pin_a = pins[1];
        it.pin_b = pins[0];
        it.tick  = tick;
        knob_stimulus.push_back(it);
        walk_pins = pins;
    endtask

    // mostly clean quadrature turning with random speed, some noise
    task automatic add_random(input int n);
        int          r;
        logic [1:0]  pins;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom());
            end else if (r < 12) begin
                push_item(1'b1, 2'($urandom_range(0, 3)), $urandom());
            end else if (r < 16) begin
                // no movement or a skipped state
                pins = $urandom_range(0, 1) ? walk_pins : ~walk_pins;
                tick_now = tick_now + $urandom_range(0, 20);
                push_item(1'b0, pins, tick_now);
            end else begin
                if ($urandom_range(0, 7) == 0)
                    walk_up = ~walk_up;
                pins = walk_up ? UP_NEXT[walk_pins] : DOWN_NEXT[walk_pins];
                if ($urandom_range(0, 15) == 0)
                    tick_now = tick_now + $urandom();
                else
                    tick_now = tick_now + $urandom_range(0, 24);
                push_item(1'b0, pins, tick_now);
            end
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rek_pkg::REG_SLOW_STEP:   knob_cfg.slow_step   = val[7:0];
            rek_pkg::REG_FAST_STEP:   knob_cfg.fast_step   = val[7:0];
            rek_pkg::REG_MAX_VALUE:   knob_cfg.max_value   = val[7:0];
            rek_pkg::REG_WRAP_MODE:   knob_cfg.wrap_mode   = val[0];
            rek_pkg::REG_FAST_WINDOW: knob_cfg.fast_window = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained;
        while (knob_stimulus.size() != 0 || knob_expected.size() != 0)
            @(posedge aclk);
    endtask

    // sender
    always @(posedge aclk) begin : drv_proc
        logic       nv;
        knob_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                knob_expected.push_back(advance_knob(s_tuser[0], {s_tdata[0], s_tdata[1]},
                                                     s_tdata[33:2]));
                it = knob_stimulus.pop_front();
            end
            nv = s_tvalid && !s_tready;
            if (!nv) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (knob_stimulus.size() > 0) begin
                    it = knob_stimulus[0];
                    s_tdata <= {6'd0, it.tick, it.pin_b, it.pin_a};
                    s_tuser <= it.kind;
                    nv = 1'b1;
                    if (jitter && $urandom_range(0, 5) == 0)
                        s_gap = $urandom_range(1, 7);
                end
            end
            s_tvalid <= nv;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : mon_proc
        logic         rdy;
        knob_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (knob_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, value %0d", m_tdata));
                end else begin
                    want = knob_expected.pop_front();
                    if (m_tuser[0] !== want.changed)
                        report_mismatch($sformatf("changed %b, want %b", m_tuser[0],
                                                  want.changed));
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("knob_value %0d, want %0d", m_tdata,
                                                  want.value));
                end
                if (results_seen == HOLD_AT)
                    hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
                if (jitter && $urandom_range(0, 4) == 0)
                    m_gap = $urandom_range(1, 7);
            end
            m_tready <= rdy;
        end
    end

    always @(posedge aclk) begin : watchdog_proc
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : main_proc
        logic [7:0]  c_slow, c_fast, c_max;
        logic        c_wrap;
        logic [31:0] c_thr;
        knob_cfg.slow_step   = rek_pkg::SLOW_STEP_RST;
        knob_cfg.fast_step   = rek_pkg::FAST_STEP_RST;
        knob_cfg.max_value   = rek_pkg::MAX_VALUE_RST;
        knob_cfg.wrap_mode   = rek_pkg::WRAP_MODE_RST;
        knob_cfg.fast_window = rek_pkg::FAST_WINDOW_RST;
        knob_st = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1)
                jitter = 1'b0;
            if (ph == 0) begin
                // capture ignores the tick, then every pin transition from each state
                push_item(1'b1, 2'b00, 32'hFFFF_FFFF);
                push_item(1'b0, 2'b00, 32'd0);
                push_item(1'b0, 2'b11, 32'd1);
                push_item(1'b0, 2'b01, 32'd2);   // down from zero clamps
                push_item(1'b0, 2'b01, 32'd3);
                push_item(1'b0, 2'b10, 32'd4);
                push_item(1'b0, 2'b11, 32'd5);
                push_item(1'b0, 2'b11, 32'd6);
                push_item(1'b0, 2'b00, 32'd7);
                push_item(1'b0, 2'b10, 32'd8);
                push_item(1'b0, 2'b10, 32'd9);
                push_item(1'b0, 2'b01, 32'd10);
                push_item(1'b0, 2'b00, 32'd11);
                // reversal is slow, then fast turning up
                push_item(1'b0, 2'b10, 32'd12);
                push_item(1'b0, 2'b11, 32'd13);
                push_item(1'b0, 2'b01, 32'd14);
                push_item(1'b0, 2'b00, 32'd15);
                // interval equal to the window is slow
                push_item(1'b0, 2'b10, 32'd25);
                push_item(1'b0, 2'b11, 32'hFFFF_FFFF);
                // tick wraps around, short interval still fast
                push_item(1'b0, 2'b01, 32'h0000_0002);
                push_item(1'b1, 2'b11, 32'd0);
                push_item(1'b0, 2'b01, 32'd5);
                tick_now = 32'd5;
            end else begin
                case (ph)
                    1: begin
                        c_slow = 8'd0;   c_fast = 8'd255; c_max = 8'd0;
                        c_wrap = 1'b1;   c_thr  = 32'd0;
                    end
                    2: begin
                        c_slow = 8'd255; c_fast = 8'd0;   c_max = 8'd255;
                        c_wrap = 1'b0;   c_thr  = 32'hFFFF_FFFF;
                    end
                    3: begin
                        c_slow = 8'd255; c_fast = 8'd255; c_max = 8'd255;
                        c_wrap = 1'b1;   c_thr  = 32'h8000_0000;
                    end
                    default: begin
                        c_slow = 8'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                         : $urandom_range(0, 255));
                        c_fast = 8'($urandom_range(0, 1) ? $urandom_range(0, 12)
                                                         : $urandom_range(0, 255));
                        c_max  = 8'($urandom_range(0, 255));
                        c_wrap = 1'($urandom_range(0, 1));
                        c_thr  = $urandom_range(0, 3) != 0 ? $urandom_range(0, 40)
                                                           : $urandom();
                    end
                endcase
                wait_drained();
                repeat (3) @(posedge aclk);
                write_reg(rek_pkg::REG_SLOW_STEP, {24'd0, c_slow});
                write_reg(rek_pkg::REG_FAST_STEP, {24'd0, c_fast});
                write_reg(rek_pkg::REG_MAX_VALUE, {24'd0, c_max});
                write_reg(rek_pkg::REG_WRAP_MODE, {31'd0, c_wrap});
                write_reg(rek_pkg::REG_FAST_WINDOW, c_thr);
            end
            add_random(RAND_PER_PHASE);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rek_pkg.sv
rtl/rek_cfg.sv
rtl/rek_step.sv
rtl/rotary_encoder_accel_knob_unit.sv
bench/rotary_encoder_accel_knob_unit_tb.sv
